### design/vcrc_pkg.sv
// Package with shared types and constants of the vector clock race checker.
`timescale 1ns / 1ps
package vcrc_pkg;
    localparam int ENTRIES = 4096;
    localparam int ADDR_BITS = 12;
    localparam int THREADS = 8;
    localparam int TID_BITS = 3;
    localparam int CLK_BITS = 16;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_AREAD    = 3'd2,
        OP_AWRITE   = 3'd3,
        OP_REC_AW   = 3'd4,
        OP_REC_PW   = 3'd5,
        OP_MARK     = 3'd6,
        OP_QUERY    = 3'd7
    } t_op;

    // Write epoch, atomic flag and epoch mark for one shadow entry.
    typedef struct packed {
        logic [TID_BITS-1:0] wt;
        logic [CLK_BITS-1:0] wc;
        logic                atom;
        logic                gen;
    } t_meta;

    typedef struct packed {
        logic [CLK_BITS-1:0] rc;
        logic                gen;
    } t_rd;
endpackage

### design/vcrc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module vcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/vector_clock_race_checker_top.sv
// Top level of the vector clock race checker.
`timescale 1ns / 1ps
// Usage: one beat on the input channel (i_valid/o_ready) carries an operation,
// an address, the thread and its eight vector clock entries. Each accepted beat
// produces exactly one result beat on the output channel (o_valid/i_ready)
// with the race report and the entry's prior write epoch and atomic flag.
// After the accepting edge the metadata state reads the entry's metadata, the
// scan state walks the read clocks one slot at a time through the single
// read-clock memory port and the single shared clock comparator, and the
// write-back state checks the eighth slot and the write epoch. o_valid rises
// in the output state after write-back, and no new item is taken until the
// result has been taken. o_ready is low while an item is at work and while a
// result waits for the receiver. A stalled receiver simply holds the result
// register, and nothing is lost.
// Reset starts a pass that writes every metadata entry and every read clock
// with zero; o_ready stays low until it ends. Reads are cleared by rewriting
// their slots during the scan and write-back.
module vector_clock_race_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_operation,
    input  logic [11:0] i_address,
    input  logic [2:0]  i_thread,
    input  logic [15:0] i_clock_0,
    input  logic [15:0] i_clock_1,
    input  logic [15:0] i_clock_2,
    input  logic [15:0] i_clock_3,
    input  logic [15:0] i_clock_4,
    input  logic [15:0] i_clock_5,
    input  logic [15:0] i_clock_6,
    input  logic [15:0] i_clock_7,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_race_found,
    output logic        o_race_with_write,
    output logic [2:0]  o_other_thread,
    output logic [15:0] o_other_clock,
    output logic [2:0]  o_prior_write_thread,
    output logic [15:0] o_prior_write_clock,
    output logic        o_nonatomic_store
);
    localparam int AB = vcrc_pkg::ADDR_BITS;
    localparam int TB = vcrc_pkg::TID_BITS;
    localparam int CA = vcrc_pkg::ADDR_BITS + vcrc_pkg::TID_BITS;
    localparam int CB = vcrc_pkg::CLK_BITS;
    localparam int MW = $bits(vcrc_pkg::t_meta);
    localparam int RW = $bits(vcrc_pkg::t_rd);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_META, S_SCAN, S_WB, S_OUT
    } t_state;

    // Note on the epoch mark: the entry's mark is one bit, so clearing reads
    // needs every read slot rewritten with the current mark; a write stores
    // zero clocks with the entry's mark over the scan instead of flipping it.
    t_state                r_state;
    logic [AB-1:0]         r_addr;
    logic [CA-1:0]         r_clr;
    logic [TB-1:0]         r_tid;
    logic [TB-1:0]         r_u;
    vcrc_pkg::t_op         r_op;
    logic [CB-1:0]         r_cv [vcrc_pkg::THREADS];
    vcrc_pkg::t_meta       r_meta;
    logic                  r_race, r_rw;
    logic [TB-1:0]         r_oth;
    logic [CB-1:0]         r_oclk;

    logic                  meta_we;
    logic [AB-1:0]         meta_addr;
    vcrc_pkg::t_meta       meta_wd, meta_rd;
    logic                  rd_we;
    logic [CA-1:0]         rd_waddr, rd_raddr;
    vcrc_pkg::t_rd         rd_wd, rd_rd;

    logic [CB-1:0]         cv_in [vcrc_pkg::THREADS];
    logic [CB-1:0]         rclk;
    logic                  rd_race, wr_race, checks, is_wr, is_rd, clr_rd;
    logic [CB-1:0]         own;
    logic [TB-1:0]         slot;

    assign cv_in = '{i_clock_0, i_clock_1, i_clock_2, i_clock_3,
                     i_clock_4, i_clock_5, i_clock_6, i_clock_7};

    vcrc_ram #(.WIDTH(MW), .DEPTH(vcrc_pkg::ENTRIES)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_addr), .i_wdata(meta_wd),
        .i_raddr(meta_addr), .o_rdata(meta_rd));

    vcrc_ram #(.WIDTH(RW), .DEPTH(vcrc_pkg::ENTRIES * vcrc_pkg::THREADS)) u_rd (
        .i_clk(i_clk), .i_we(rd_we), .i_waddr(rd_waddr), .i_wdata(rd_wd),
        .i_raddr(rd_raddr), .o_rdata(rd_rd));

    assign own   = r_cv[r_tid];
    assign is_wr = (r_op == vcrc_pkg::OP_WRITE) || (r_op == vcrc_pkg::OP_AWRITE);
    assign is_rd = (r_op == vcrc_pkg::OP_READ);
    assign clr_rd = is_rd || is_wr || r_op == vcrc_pkg::OP_REC_AW ||
                    r_op == vcrc_pkg::OP_REC_PW;
    assign checks = is_rd || (r_op == vcrc_pkg::OP_WRITE) ||
                    (!r_meta.atom && (r_op == vcrc_pkg::OP_AWRITE ||
                                      r_op == vcrc_pkg::OP_AREAD));
    // The read data is registered, so the slot under
    // evaluation is one behind r_u; in write-back r_u has wrapped to zero.
    assign slot = r_u - TB'(1);
    // Read clock of the slot being evaluated; a stale mark means none.
    assign rclk = (rd_rd.gen == r_meta.gen) ? rd_rd.rc : '0;
    // The shared comparator: prior read clock against the current vector.
    assign rd_race = (slot != r_tid) && (rclk != '0) && (r_cv[slot] <= rclk);
    assign wr_race = (r_meta.wt != r_tid) && (r_meta.wc != '0) &&
                     (r_cv[r_meta.wt] <= r_meta.wc);

    always_comb begin
        meta_we   = 1'b0;
        meta_addr = i_address;
        meta_wd   = r_meta;
        rd_we     = 1'b0;
        rd_raddr  = {r_addr, r_u};
        rd_waddr  = {r_addr, slot};
        rd_wd     = '{rc: '0, gen: r_meta.gen};
        // A read keeps only the prior reads that may still race and
        // records its own clock; every other update clears the slot.
        if (is_rd) begin
            if (slot == r_tid) begin
                rd_wd.rc = own;
            end else if (rd_race) begin
                rd_wd.rc = rclk;
            end
        end
        case (r_state)
            S_CLEAR: begin
                meta_we   = 1'b1;
                meta_addr = r_clr[AB-1:0];
                meta_wd   = '0;
                rd_we     = 1'b1;
                rd_waddr  = r_clr;
                rd_wd     = '0;
            end
            S_IDLE: meta_addr = i_address;
            S_SCAN: begin
                meta_addr = r_addr;
                rd_we     = clr_rd;
            end
            S_WB: begin
                meta_addr = r_addr;
                meta_we   = 1'b1;
                rd_we     = clr_rd;
                case (r_op)
                    vcrc_pkg::OP_WRITE, vcrc_pkg::OP_REC_PW: begin
                        meta_wd.wt = r_tid; meta_wd.wc = own; meta_wd.atom = 1'b0;
                    end
                    vcrc_pkg::OP_AWRITE, vcrc_pkg::OP_REC_AW: begin
                        meta_wd.wt = r_tid; meta_wd.wc = own; meta_wd.atom = 1'b1;
                    end
                    vcrc_pkg::OP_MARK: meta_wd.atom = 1'b1;
                    default: ;
                endcase
            end
            default: meta_addr = r_addr;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            o_valid <= 1'b0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CA'(1);
                    if (r_clr == CA'(vcrc_pkg::ENTRIES * vcrc_pkg::THREADS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: if (i_valid) begin
                    r_addr  <= i_address;
                    r_tid   <= i_thread;
                    r_op    <= vcrc_pkg::t_op'(i_operation);
                    r_cv    <= cv_in;
                    r_u     <= '0;
                    r_state <= S_META;
                end
                S_META: begin
                    r_meta  <= meta_rd;
                    r_race  <= 1'b0;
                    r_rw    <= 1'b0;
                    r_oth   <= '0;
                    r_oclk  <= '0;
                    r_u     <= TB'(1);
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // Slots are evaluated in rising thread order; the first
                    // racing read wins.
                    if (is_wr && checks && rd_race && !r_race) begin
                        r_race <= 1'b1; r_oth <= slot; r_oclk <= rclk;
                    end
                    r_u <= r_u + TB'(1);
                    if (r_u == TB'(vcrc_pkg::THREADS - 1)) r_state <= S_WB;
                end
                S_WB: begin
                    // The last read slot comes first, then the write epoch.
                    if (is_wr && checks && rd_race && !r_race) begin
                        r_race <= 1'b1; r_oth <= slot; r_oclk <= rclk;
                    end else if (checks && wr_race && !(is_wr && r_race)) begin
                        r_race <= 1'b1; r_rw <= 1'b1;
                        r_oth <= r_meta.wt; r_oclk <= r_meta.wc;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (!o_valid) begin
                    o_valid <= 1'b1;
                end else if (i_ready) begin
                    o_valid <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_race_found = r_race;
    assign o_race_with_write = r_rw;
    assign o_other_thread = r_oth;
    assign o_other_clock = r_oclk;
    assign o_prior_write_thread = r_meta.wt;
    assign o_prior_write_clock = r_meta.wc;
    assign o_nonatomic_store = !r_meta.atom;
endmodule

### test/vector_clock_race_checker_top_tb.sv
// Testbench for the vector clock race checker: random and directed accesses.
`timescale 1ns / 1ps
module vector_clock_race_checker_top_tb;

    // One expected result beat.
    typedef struct {
        logic        race;
        logic        with_write;
        logic [2:0]  oth;
        logic [15:0] oclk;
        logic [2:0]  pwt;
        logic [15:0] pwc;
        logic        nonatomic;
    } t_report;

    // Scoreboard: keeps its own shadow memory and a queue of expected reports.
    class race_scoreboard;
        logic [2:0]  wr_thread [vcrc_pkg::ENTRIES];
        logic [15:0] wr_clock [vcrc_pkg::ENTRIES];
        logic        atomic_flag [vcrc_pkg::ENTRIES];
        logic [15:0] rd_clock [vcrc_pkg::ENTRIES][vcrc_pkg::THREADS];
        t_report     pending [$];
        int          errors;
        int          checked;
        int          races;

        function new();
            foreach (wr_thread[a]) begin
                wr_thread[a] = '0;
                wr_clock[a] = '0;
                atomic_flag[a] = 1'b0;
                for (int u = 0; u < vcrc_pkg::THREADS; u++) rd_clock[a][u] = '0;
            end
            errors = 0;
            checked = 0;
            races = 0;
        endfunction

        // A prior epoch (who, c) can race with thread me holding vector vc.
        function bit conflicts(logic [15:0] vc[vcrc_pkg::THREADS], int me,
                               logic [15:0] c, int who);
            return who != me && c != 0 && vc[who] <= c;
        endfunction

        // Notes an accepted access: updates the shadow copy and queues its report.
        function void note_access(vcrc_pkg::t_op op, logic [11:0] addr, logic [2:0] tid,
                                  logic [15:0] vc[vcrc_pkg::THREADS]);
            t_report r;
            int t;
            bit atom;
            t = tid;
            atom = atomic_flag[addr];
            r.race = 0; r.with_write = 0; r.oth = '0; r.oclk = '0;
            r.pwt = wr_thread[addr];
            r.pwc = wr_clock[addr];
            r.nonatomic = !atom;
            case (op)
                vcrc_pkg::OP_READ: begin
                    if (conflicts(vc, t, wr_clock[addr], wr_thread[addr])) begin
                        r.race = 1; r.with_write = 1;
                        r.oth = wr_thread[addr]; r.oclk = wr_clock[addr];
                    end
                    for (int u = 0; u < vcrc_pkg::THREADS; u++)
                        if (!conflicts(vc, t, rd_clock[addr][u], u)) rd_clock[addr][u] = '0;
                    rd_clock[addr][t] = vc[t];
                end
                vcrc_pkg::OP_WRITE, vcrc_pkg::OP_AWRITE: begin
                    if (!(op == vcrc_pkg::OP_AWRITE && atom)) begin
                        for (int u = 0; u < vcrc_pkg::THREADS && !r.race; u++)
                            if (conflicts(vc, t, rd_clock[addr][u], u)) begin
                                r.race = 1; r.oth = 3'(u); r.oclk = rd_clock[addr][u];
                            end
                        if (!r.race && conflicts(vc, t, wr_clock[addr], wr_thread[addr])) begin
                            r.race = 1; r.with_write = 1;
                            r.oth = wr_thread[addr]; r.oclk = wr_clock[addr];
                        end
                    end
                    for (int u = 0; u < vcrc_pkg::THREADS; u++) rd_clock[addr][u] = '0;
                    wr_thread[addr] = tid;
                    wr_clock[addr] = vc[t];
                    atomic_flag[addr] = (op == vcrc_pkg::OP_AWRITE);
                end
                vcrc_pkg::OP_AREAD: begin
                    if (!atom && conflicts(vc, t, wr_clock[addr], wr_thread[addr])) begin
                        r.race = 1; r.with_write = 1;
                        r.oth = wr_thread[addr]; r.oclk = wr_clock[addr];
                    end
                end
                vcrc_pkg::OP_REC_AW, vcrc_pkg::OP_REC_PW: begin
                    for (int u = 0; u < vcrc_pkg::THREADS; u++) rd_clock[addr][u] = '0;
                    wr_thread[addr] = tid;
                    wr_clock[addr] = vc[t];
                    atomic_flag[addr] = (op == vcrc_pkg::OP_REC_AW);
                end
                vcrc_pkg::OP_MARK: atomic_flag[addr] = 1'b1;
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        // Compares one result beat with the oldest expected report.
        function void check_result(t_report got);
            t_report e;
            if (pending.size() == 0) begin
                $error("result beat with no access outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.race) races++;
            if (got.race !== e.race) begin
                $error("race_found exp %0d got %0d", e.race, got.race); errors++;
            end
            if (got.with_write !== e.with_write) begin
                $error("race_with_write exp %0d got %0d", e.with_write, got.with_write);
                errors++;
            end
            if (got.oth !== e.oth) begin
                $error("other_thread exp %0d got %0d", e.oth, got.oth); errors++;
            end
            if (got.oclk !== e.oclk) begin
                $error("other_clock exp %0d got %0d", e.oclk, got.oclk); errors++;
            end
            if (got.pwt !== e.pwt) begin
                $error("prior_write_thread exp %0d got %0d", e.pwt, got.pwt); errors++;
            end
            if (got.pwc !== e.pwc) begin
                $error("prior_write_clock exp %0d got %0d", e.pwc, got.pwc); errors++;
            end
            if (got.nonatomic !== e.nonatomic) begin
                $error("nonatomic_store exp %0d got %0d", e.nonatomic, got.nonatomic);
                errors++;
            end
        endfunction
    endclass

    localparam int N_RANDOM = 2000;
    // Clearing pass plus the work on every item, idling and the long stall,
    // taken several times over.
    localparam int CYCLE_LIMIT = 400000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [11:0] i_address;
    logic [2:0]  i_thread;
    logic [15:0] i_clock_0, i_clock_1, i_clock_2, i_clock_3;
    logic [15:0] i_clock_4, i_clock_5, i_clock_6, i_clock_7;
    logic        o_valid;
    logic        i_ready;
    logic        o_race_found;
    logic        o_race_with_write;
    logic [2:0]  o_other_thread;
    logic [15:0] o_other_clock;
    logic [2:0]  o_prior_write_thread;
    logic [15:0] o_prior_write_clock;
    logic        o_nonatomic_store;

    race_scoreboard sb;
    int  cycle_count;
    bit  quiet_phase;     // no idling on either side once set
    bit  hold_receiver;   // asks the receiver process for one long stall
    int  accepted;

    vector_clock_race_checker_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter with the global timeout.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, and
    // a check of every result beat accepted at this edge.
    initial begin
        int burst;
        t_report got;
        i_ready = 1'b0;
        burst = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                got.race = o_race_found;
                got.with_write = o_race_with_write;
                got.oth = o_other_thread;
                got.oclk = o_other_clock;
                got.pwt = o_prior_write_thread;
                got.pwc = o_prior_write_clock;
                got.nonatomic = o_nonatomic_store;
                sb.check_result(got);
            end
            if (hold_receiver) begin
                hold_receiver = 1'b0;
                burst = 300;
            end else if (burst == 0 && !quiet_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 3);
            end
            if (burst > 0) begin
                burst--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Puts one access on the input channel and waits until it is taken.
    // Valid stays high into the next access unless an idle gap comes first.
    // The access is noted in the scoreboard at the accepting edge.
    task automatic send_access(vcrc_pkg::t_op op, logic [11:0] addr, logic [2:0] tid,
                               logic [15:0] vc[vcrc_pkg::THREADS]);
        int gap;
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        i_thread <= tid;
        i_clock_0 <= vc[0]; i_clock_1 <= vc[1]; i_clock_2 <= vc[2]; i_clock_3 <= vc[3];
        i_clock_4 <= vc[4]; i_clock_5 <= vc[5]; i_clock_6 <= vc[6]; i_clock_7 <= vc[7];
        do @(posedge i_clk); while (!(o_ready && i_valid));
        sb.note_access(op, addr, tid, vc);
        accepted++;
    endtask

    // Random vector clock; small values in a narrow window make races and
    // happens-before orderings both frequent.
    task automatic pick_clocks(output logic [15:0] vc[vcrc_pkg::THREADS]);
        int mode;
        mode = $urandom_range(0, 9);
        for (int u = 0; u < vcrc_pkg::THREADS; u++) begin
            if (mode == 0) vc[u] = 16'($urandom_range(0, 65535));
            else if (mode == 1) vc[u] = 16'($urandom_range(65530, 65535));
            else vc[u] = 16'($urandom_range(0, 6));
        end
    endtask

    initial begin
        logic [15:0] vc[vcrc_pkg::THREADS];
        logic [11:0] addr;
        vcrc_pkg::t_op op;
        sb = new();
        quiet_phase = 1'b0;
        hold_receiver = 1'b0;
        accepted = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_operation = vcrc_pkg::OP_QUERY;
        i_address = '0;
        i_thread = '0;
        {i_clock_0, i_clock_1, i_clock_2, i_clock_3} = '0;
        {i_clock_4, i_clock_5, i_clock_6, i_clock_7} = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every operation on a couple of addresses, all-zero and
        // all-ones clocks, a zero own clock, and the highest address and thread.
        for (int u = 0; u < vcrc_pkg::THREADS; u++) vc[u] = '0;
        send_access(vcrc_pkg::OP_QUERY, 12'd0, 3'd0, vc);
        send_access(vcrc_pkg::OP_READ, 12'hFFF, 3'd7, vc);   // zero own clock stores none
        send_access(vcrc_pkg::OP_WRITE, 12'hFFF, 3'd1, vc);
        for (int u = 0; u < vcrc_pkg::THREADS; u++) vc[u] = 16'd5;
        send_access(vcrc_pkg::OP_WRITE, 12'd7, 3'd2, vc);
        send_access(vcrc_pkg::OP_READ, 12'd7, 3'd3, vc);     // write by 2 not ordered: race
        send_access(vcrc_pkg::OP_READ, 12'd7, 3'd4, vc);
        send_access(vcrc_pkg::OP_WRITE, 12'd7, 3'd5, vc);    // lowest reader reported
        vc[5] = 16'd9;
        send_access(vcrc_pkg::OP_READ, 12'd7, 3'd0, vc);
        send_access(vcrc_pkg::OP_AREAD, 12'd7, 3'd1, vc);
        send_access(vcrc_pkg::OP_MARK, 12'd7, 3'd6, vc);
        send_access(vcrc_pkg::OP_AREAD, 12'd7, 3'd1, vc);    // flag set: no check
        send_access(vcrc_pkg::OP_AWRITE, 12'd7, 3'd2, vc);
        send_access(vcrc_pkg::OP_REC_AW, 12'd8, 3'd3, vc);
        send_access(vcrc_pkg::OP_AWRITE, 12'd8, 3'd4, vc);
        send_access(vcrc_pkg::OP_REC_PW, 12'd8, 3'd6, vc);
        send_access(vcrc_pkg::OP_AWRITE, 12'd8, 3'd7, vc);
        for (int u = 0; u < vcrc_pkg::THREADS; u++) vc[u] = 16'hFFFF;
        send_access(vcrc_pkg::OP_WRITE, 12'hFFF, 3'd7, vc);
        send_access(vcrc_pkg::OP_READ, 12'hFFF, 3'd0, vc);
        send_access(vcrc_pkg::OP_QUERY, 12'hFFF, 3'd7, vc);

        // Random part on a small pool of hot addresses, with the odd address
        // anywhere in the store so every address bit is exercised.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 400) hold_receiver = 1'b1;
            if (n == N_RANDOM - 300) quiet_phase = 1'b1;
            pick_clocks(vc);
            if ($urandom_range(0, 9) == 0) addr = 12'($urandom_range(0, 4095));
            else addr = {$urandom_range(0, 1) ? 4'hF : 4'h0, 4'h0, 4'($urandom_range(0, 7))};
            op = vcrc_pkg::t_op'($urandom_range(0, 7));
            send_access(op, addr, 3'($urandom_range(0, 7)), vc);
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        $display("Covered %0d accesses over all operations; %0d results checked, %0d races.",
                 accepted, sb.checked, sb.races);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
